@@ rtl/core/basic_upcount_timer_core_assert.svh @@
// assertion macros for the basic up-count timer core
// used by the execution stage; no other dependencies
`ifndef BASIC_UPCOUNT_TIMER_CORE_ASSERT_SVH
`define BASIC_UPCOUNT_TIMER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bt_pkg.sv @@
// shared types and constants of the basic up-count timer core
// no dependencies; imported by every module of the block
package bt_pkg;

    // default counter width and queue depth
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int QUEUE_DEPTH     = 2;

    // operation codes on the input beat
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register byte offsets
    localparam logic [5:0] OFS_CR1  = 6'd0;
    localparam logic [5:0] OFS_CR2  = 6'd4;
    localparam logic [5:0] OFS_DIER = 6'd12;
    localparam logic [5:0] OFS_SR   = 6'd16;
    localparam logic [5:0] OFS_EGR  = 6'd20;
    localparam logic [5:0] OFS_CNT  = 6'd36;
    localparam logic [5:0] OFS_PSC  = 6'd40;
    localparam logic [5:0] OFS_ARR  = 6'd44;

    // cr1 bit positions and writable mask
    localparam int B_CEN   = 0;
    localparam int B_UDIS  = 1;
    localparam int B_URS   = 2;
    localparam int B_OPM   = 3;
    localparam int B_ARPE  = 7;
    localparam int B_REMAP = 11;
    localparam logic [11:0] CR1_WMASK = 12'h88F;

    // master mode codes
    localparam logic [2:0] MMS_RESET  = 3'd0;
    localparam logic [2:0] MMS_ENABLE = 3'd1;
    localparam logic [2:0] MMS_UPDATE = 3'd2;

    // decoded operation kind
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_READ,
        KIND_WRITE,
        KIND_NOP
    } t_kind;

    // decoded register select
    typedef enum logic [3:0] {
        REG_CR1,
        REG_CR2,
        REG_DIER,
        REG_SR,
        REG_EGR,
        REG_CNT,
        REG_PSC,
        REG_ARR,
        REG_NONE
    } t_reg;

    // classified command handed from front to back
    typedef struct packed {
        t_kind       kind;
        t_reg        regsel;
        logic [15:0] data;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic [31:0] read_data;
        logic        update_event;
        logic        interrupt_line;
        logic        trigger_out;
    } t_result;

endpackage

@@ rtl/core/basic_upcount_timer_core.sv @@
// Basic up-count timer with prescaler and auto-reload.
// Input channel: push/full queue; each beat is a counter tick, a register
// read, a register write or a no-op (i_operation, i_reg_offset,
// i_write_data). A beat is taken at a clock edge with push high and full low.
// Result channel: empty/pop queue; every input beat yields exactly one
// result beat (read data, update event, interrupt line, trigger out), in
// order. The oldest result sits on the o_ ports while empty is low and is
// taken at an edge with pop high and empty low.
// A beat in the command queue is executed once it heads that queue and the
// result queue has room; its result is registered into the result queue.
// Throughput: one beat per cycle when the result queue has room, set by the
// register-updating execute stage; two-entry queues sit before and after it.
// Receiver stall: results collect in the output queue, then commands in the
// input queue; full rises once both are full, and nothing is dropped.
// Reset (i_rst_n low, synchronous): queues empty, timer registers at their
// reset values, auto-reload values all ones.
module basic_upcount_timer_core import bt_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_reg_offset,
    input  logic [15:0] i_write_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_read_data,
    output logic        o_update_event,
    output logic        o_interrupt_line,
    output logic        o_trigger_out
);
    logic                       w_cmd_valid;
    t_cmd                       w_cmd;
    logic                       w_cmd_pop;
    logic                       w_res_valid;
    t_result                    w_res;
    logic                       w_resq_full;
    logic [$bits(t_result)-1:0] w_res_out;
    t_result                    w_res_head;

    // decode and command queue
    bt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_operation  (i_operation),
        .i_reg_offset (i_reg_offset),
        .i_write_data (i_write_data),
        .o_full       (full),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_pop    (w_cmd_pop)
    );

    // timer execution
    bt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_ready (!w_resq_full),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result queue
    bt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_resq_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    // result ports
    assign w_res_head       = t_result'(w_res_out);
    assign o_read_data      = w_res_head.read_data;
    assign o_update_event   = w_res_head.update_event;
    assign o_interrupt_line = w_res_head.interrupt_line;
    assign o_trigger_out    = w_res_head.trigger_out;

endmodule

@@ rtl/core/bt_fifo.sv @@
// small first-in first-out queue of packed words
// uses bt_pkg for the default depth
module bt_fifo import bt_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    // handshake qualification
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rptr];

    // storage write
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push_ok) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push_ok && w_pop_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/bt_front.sv @@
// front end: classifies input beats and queues them for execution
// uses bt_pkg types and bt_fifo
module bt_front import bt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_reg_offset,
    input  logic [15:0] i_write_data,
    output logic        o_full,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);
    t_cmd                    w_cmd;
    logic [$bits(t_cmd)-1:0] w_cmd_out;
    logic                    w_empty;

    // operation and register decode
    always_comb begin
        w_cmd.data = i_write_data;
        unique case (i_operation)
            OP_TICK:  w_cmd.kind = KIND_TICK;
            OP_READ:  w_cmd.kind = KIND_READ;
            OP_WRITE: w_cmd.kind = KIND_WRITE;
            default:  w_cmd.kind = KIND_NOP;
        endcase
        unique case (i_reg_offset)
            OFS_CR1:  w_cmd.regsel = REG_CR1;
            OFS_CR2:  w_cmd.regsel = REG_CR2;
            OFS_DIER: w_cmd.regsel = REG_DIER;
            OFS_SR:   w_cmd.regsel = REG_SR;
            OFS_EGR:  w_cmd.regsel = REG_EGR;
            OFS_CNT:  w_cmd.regsel = REG_CNT;
            OFS_PSC:  w_cmd.regsel = REG_PSC;
            OFS_ARR:  w_cmd.regsel = REG_ARR;
            default:  w_cmd.regsel = REG_NONE;
        endcase
    end

    // command queue toward the execution stage
    bt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_empty)
    );

    assign o_cmd       = t_cmd'(w_cmd_out);
    assign o_cmd_valid = !w_empty;

endmodule

@@ rtl/core/bt_back.sv @@
// back end: timer registers, counting and update logic, one command a cycle while the result queue has room
// uses bt_pkg types and the assertion macro header
`include "basic_upcount_timer_core_assert.svh"

module bt_back import bt_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_ready,
    output logic    o_res_valid,
    output t_result o_res
);
    logic [11:0]            r_ctrl, n_ctrl;
    logic [2:0]             r_mms, n_mms;
    logic                   r_uie, n_uie;
    logic                   r_uif, n_uif;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [15:0]            r_psc_cnt, n_psc_cnt;
    logic [15:0]            r_psc_pre, n_psc_pre;
    logic [15:0]            r_psc_sh, n_psc_sh;
    logic [COUNT_WIDTH-1:0] r_arr_pre, n_arr_pre;
    logic [COUNT_WIDTH-1:0] r_arr_sh, n_arr_sh;

    logic        w_fire;
    logic        w_upd;
    logic        w_set_flag;
    logic        w_ug;
    logic        w_trig;
    logic [31:0] w_rd;
    logic        w_ug_write;

    // one command executes when a result slot is free
    assign w_fire      = i_cmd_valid && i_res_ready;
    assign o_cmd_pop   = w_fire;
    assign o_res_valid = w_fire;

    // next state of the timer for the command at the head of the queue
    always_comb begin
        n_ctrl     = r_ctrl;
        n_mms      = r_mms;
        n_uie      = r_uie;
        n_uif      = r_uif;
        n_cnt      = r_cnt;
        n_psc_cnt  = r_psc_cnt;
        n_psc_pre  = r_psc_pre;
        n_psc_sh   = r_psc_sh;
        n_arr_pre  = r_arr_pre;
        n_arr_sh   = r_arr_sh;
        w_upd      = 1'b0;
        w_set_flag = 1'b0;
        w_ug       = 1'b0;
        w_rd       = '0;
        unique case (i_cmd.kind)
            KIND_TICK: begin
                if (r_ctrl[B_CEN]) begin
                    if (r_psc_cnt >= r_psc_sh) begin
                        n_psc_cnt = '0;
                        if (r_cnt == r_arr_sh) begin
                            n_cnt      = '0;
                            w_upd      = !r_ctrl[B_UDIS];
                            w_set_flag = 1'b1;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        n_psc_cnt = r_psc_cnt + 16'd1;
                    end
                end
            end
            KIND_READ: begin
                unique case (i_cmd.regsel)
                    REG_CR1:  w_rd = 32'(r_ctrl);
                    REG_CR2:  w_rd = 32'({r_mms, 4'b0000});
                    REG_DIER: w_rd = 32'(r_uie);
                    REG_SR:   w_rd = 32'(r_uif);
                    REG_CNT: begin
                        w_rd     = 32'(r_cnt);
                        w_rd[31] = r_ctrl[B_REMAP] && r_uif;
                    end
                    REG_PSC:  w_rd = 32'(r_psc_pre);
                    REG_ARR:  w_rd = 32'(r_arr_pre);
                    default:  w_rd = '0;
                endcase
            end
            KIND_WRITE: begin
                unique case (i_cmd.regsel)
                    REG_CR1:  n_ctrl = i_cmd.data[11:0] & CR1_WMASK;
                    REG_CR2:  n_mms  = i_cmd.data[6:4];
                    REG_DIER: n_uie  = i_cmd.data[0];
                    REG_SR: begin
                        if (!i_cmd.data[0]) begin
                            n_uif = 1'b0;
                        end
                    end
                    REG_EGR: begin
                        if (i_cmd.data[0]) begin
                            w_ug       = 1'b1;
                            n_cnt      = '0;
                            n_psc_cnt  = '0;
                            w_upd      = !r_ctrl[B_UDIS];
                            w_set_flag = !r_ctrl[B_URS];
                        end
                    end
                    REG_CNT:  n_cnt     = COUNT_WIDTH'(i_cmd.data);
                    REG_PSC:  n_psc_pre = i_cmd.data;
                    REG_ARR: begin
                        n_arr_pre = COUNT_WIDTH'(i_cmd.data);
                        if (!r_ctrl[B_ARPE]) begin
                            n_arr_sh = COUNT_WIDTH'(i_cmd.data);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // update event: flag, shadow loads, one-pulse stop
        if (w_upd) begin
            if (w_set_flag) begin
                n_uif = 1'b1;
            end
            n_psc_sh = r_psc_pre;
            if (r_ctrl[B_ARPE]) begin
                n_arr_sh = r_arr_pre;
            end
            if (r_ctrl[B_OPM]) begin
                n_ctrl[B_CEN] = 1'b0;
            end
        end

        // master trigger selection
        unique case (n_mms)
            MMS_RESET:  w_trig = w_ug;
            MMS_ENABLE: w_trig = n_ctrl[B_CEN];
            MMS_UPDATE: w_trig = w_upd;
            default:    w_trig = 1'b0;
        endcase
    end

    // result beat
    assign o_res.read_data      = w_rd;
    assign o_res.update_event   = w_upd;
    assign o_res.interrupt_line = n_uif && n_uie;
    assign o_res.trigger_out    = w_trig;

    // timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_mms     <= '0;
            r_uie     <= 1'b0;
            r_uif     <= 1'b0;
            r_cnt     <= '0;
            r_psc_cnt <= '0;
            r_psc_pre <= '0;
            r_psc_sh  <= '0;
            r_arr_pre <= '1;
            r_arr_sh  <= '1;
        end else if (w_fire) begin
            r_ctrl    <= n_ctrl;
            r_mms     <= n_mms;
            r_uie     <= n_uie;
            r_uif     <= n_uif;
            r_cnt     <= n_cnt;
            r_psc_cnt <= n_psc_cnt;
            r_psc_pre <= n_psc_pre;
            r_psc_sh  <= n_psc_sh;
            r_arr_pre <= n_arr_pre;
            r_arr_sh  <= n_arr_sh;
        end
    end

    // checks
    assign w_ug_write = w_fire && (i_cmd.kind == KIND_WRITE)
                        && (i_cmd.regsel == REG_EGR) && i_cmd.data[0];

    `BT_ASSERT_NEXT(a_ug_reinit, i_clk, i_rst_n, w_ug_write, (r_cnt == '0) && (r_psc_cnt == '0), "ug did not clear counters")
    `BT_ASSERT_NEXT(a_opm_stop, i_clk, i_rst_n, w_fire && w_upd && r_ctrl[B_OPM], !r_ctrl[B_CEN], "one-pulse update left counter enabled")
    `BT_ASSERT_NEXT(a_idle_tick, i_clk, i_rst_n, w_fire && (i_cmd.kind == KIND_TICK) && !r_ctrl[B_CEN], $stable(r_cnt) && $stable(r_psc_cnt), "disabled tick moved a counter")

endmodule
